// ===== src/sm4_ctr_keystream_xor_assert.svh =====
// Assertion macros shared by the SM4 counter-mode engine.
// No dependencies; included by sm4_ctr_keystream_xor, which checks itself.
`ifndef SM4_CTR_KEYSTREAM_XOR_ASSERT_SVH
`define SM4_CTR_KEYSTREAM_XOR_ASSERT_SVH

// Same-cycle implication, quiet during reset.
`define SM4_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sm4 check failed");

// Next-cycle implication, quiet during reset.
`define SM4_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sm4 check failed");

`endif

// ===== src/sm4ctr_pkg.sv =====
// Shared types, constants and round functions of the SM4 counter-mode engine.
// No dependencies.
package sm4ctr_pkg;

   localparam int ROUND_COUNT = 32;
   localparam int KEY_IDX_W   = $clog2(ROUND_COUNT);
   localparam int BLOCK_W     = 128;
   localparam logic [4:0] FULL_COUNT = 5'd16;

   typedef enum logic [1:0] {
      OP_KEY     = 2'd0,
      OP_COUNTER = 2'd1,
      OP_CHUNK   = 2'd2,
      OP_RSVD    = 2'd3
   } opcode_type;

   // Bus handed from one round cell to the next.
   typedef struct packed {
      logic               vld;
      logic [BLOCK_W-1:0] blk;
   } cell_bus_type;

   localparam logic [7:0] SBOX [256] = '{
      8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
      8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
      8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
      8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
      8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
      8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
      8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
      8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
      8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
      8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
      8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
      8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
      8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
      8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
      8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
      8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
   };

   // Byte-wise S-box substitution.
   function automatic logic [31:0] tau_word(input logic [31:0] v);
      return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
   endfunction

   // Linear diffusion L.
   function automatic logic [31:0] lin_word(input logic [31:0] b);
      return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
               ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
   endfunction

endpackage

// ===== src/sm4ctr_round_cell.sv =====
// One SM4 round cell: holds its round key and one registered block stage.
// Depends on sm4ctr_pkg.
module sm4ctr_round_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      key_we,
   input  logic [31:0]               key_word,
   input  sm4ctr_pkg::cell_bus_type  bus_in,
   output sm4ctr_pkg::cell_bus_type  bus_out
);

   logic [31:0]               key_ff;
   logic                      vld_ff;
   logic [sm4ctr_pkg::BLOCK_W-1:0] blk_ff;
   logic [sm4ctr_pkg::BLOCK_W-1:0] blk_in;
   logic [31:0]               w4;

   // One round: new word from the top word, the lower three words and the key, shift left.
   always_comb begin
      w4 = bus_in.blk[127:96] ^ sm4ctr_pkg::lin_word(sm4ctr_pkg::tau_word(
              bus_in.blk[95:64] ^ bus_in.blk[63:32] ^ bus_in.blk[31:0] ^ key_ff));
      blk_in = {bus_in.blk[95:0], w4};
   end

   // Round key register, written while the engine is idle.
   always_ff @(posedge clock) begin
      if (key_we) begin
         key_ff <= key_word;
      end
   end

   // Stage register handed on to the next cell.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= bus_in.vld;
      end
      blk_ff <= blk_in;
   end

   assign bus_out.vld = vld_ff;
   assign bus_out.blk = blk_ff;

endmodule

// ===== src/sm4_ctr_keystream_xor.sv =====
// Top level of the SM4 counter-mode engine: counter, cell row, output XOR.
// Depends on sm4ctr_pkg, sm4ctr_round_cell and sm4_ctr_keystream_xor_assert.svh.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall| opcode, key_index, key_word, data, count
//  rsp     | out       | rsp_valid/rsp_stall| out_high, out_low, out_count
//
// A chunk request runs through 32 round cells, one round per cycle, and the
// masked result is registered for the response; one chunk is in flight at a time.
// Key and counter loads give no response.
// req_stall is high from a chunk's acceptance until its response is taken.
// Reset is synchronous; it zeroes the counter, round keys stay undefined.
`include "sm4_ctr_keystream_xor_assert.svh"
module sm4_ctr_keystream_xor (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [4:0]  req_key_index,
   input  logic [31:0] req_key_word,
   input  logic [63:0] req_data_high,
   input  logic [63:0] req_data_low,
   input  logic [4:0]  req_byte_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_high,
   output logic [63:0] rsp_out_low,
   output logic [4:0]  rsp_out_count
);

   localparam int RC = sm4ctr_pkg::ROUND_COUNT;

   logic        busy_ff, busy_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] ctr_high_ff;
   logic [31:0] ctr_mid_ff;
   logic [31:0] ctr_word_ff;
   logic [127:0] data_ff;
   logic [4:0]  count_ff;
   logic [63:0] out_high_ff, out_low_ff;
   logic [4:0]  out_count_ff;
   logic        req_take, key_wr, ctr_wr, chunk_go, rsp_take;
   logic [4:0]  count_sat;
   logic [127:0] ks, xored, mask;
   logic [RC-1:0] cell_vld;
   sm4ctr_pkg::cell_bus_type bus [RC+1];

   // Request decode.
   always_comb begin
      req_take = req_valid && !busy_ff;
      key_wr   = req_take && (req_opcode == sm4ctr_pkg::OP_KEY);
      ctr_wr   = req_take && (req_opcode == sm4ctr_pkg::OP_COUNTER);
      chunk_go = req_take && (req_opcode == sm4ctr_pkg::OP_CHUNK) && (req_byte_count != 5'd0);
      count_sat = (req_byte_count > sm4ctr_pkg::FULL_COUNT) ? sm4ctr_pkg::FULL_COUNT
                                                            : req_byte_count;
      rsp_take = rsp_valid_ff && !rsp_stall;
   end

   // The first cell takes the current counter block.
   assign bus[0].vld = chunk_go;
   assign bus[0].blk = {ctr_high_ff, ctr_mid_ff, ctr_word_ff};

   // Row of round cells, each holding its own round key.
   for (genvar k = 0; k < RC; k++) begin : g_cell
      sm4ctr_round_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .key_we   (key_wr && (req_key_index == sm4ctr_pkg::KEY_IDX_W'(k))),
         .key_word (req_key_word),
         .bus_in   (bus[k]),
         .bus_out  (bus[k+1])
      );
      assign cell_vld[k] = bus[k+1].vld;
   end

   // Keystream in reversed word order, XOR and byte mask.
   always_comb begin
      ks = {bus[RC].blk[31:0], bus[RC].blk[63:32], bus[RC].blk[95:64], bus[RC].blk[127:96]};
      xored = data_ff ^ ks;
      for (int i = 0; i < 16; i++) begin
         mask[127-8*i -: 8] = (5'(i) < count_ff) ? 8'hff : 8'h00;
      end
   end

   // Engine control.
   always_comb begin
      busy_in = busy_ff;
      rsp_valid_in = rsp_valid_ff;
      if (chunk_go) begin
         busy_in = 1'b1;
      end
      if (bus[RC].vld) begin
         rsp_valid_in = 1'b1;
      end
      if (rsp_take) begin
         rsp_valid_in = 1'b0;
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         ctr_high_ff  <= '0;
         ctr_mid_ff   <= '0;
         ctr_word_ff  <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (ctr_wr) begin
            ctr_high_ff <= req_data_high;
            ctr_mid_ff  <= req_data_low[63:32];
            ctr_word_ff <= req_data_low[31:0];
         end else if (chunk_go) begin
            ctr_word_ff <= ctr_word_ff + 32'd1;
         end
      end
   end

   // Chunk payload and response registers.
   always_ff @(posedge clock) begin
      if (chunk_go) begin
         data_ff  <= {req_data_high, req_data_low};
         count_ff <= count_sat;
      end
      if (bus[RC].vld) begin
         out_high_ff  <= xored[127:64] & mask[127:64];
         out_low_ff   <= xored[63:0] & mask[63:0];
         out_count_ff <= count_ff;
      end
   end

   assign req_stall     = busy_ff;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_high  = out_high_ff;
   assign rsp_out_low   = out_low_ff;
   assign rsp_out_count = out_count_ff;

   `SM4_ASSERT_NOW(a_one_in_flight, clock, reset, 1'b1, $onehot0({cell_vld, rsp_valid_ff}))
   `SM4_ASSERT_NOW(a_busy_covers, clock, reset, (|cell_vld) || rsp_valid_ff, busy_ff)
   `SM4_ASSERT_NEXT(a_start_cell, clock, reset, chunk_go, cell_vld[0] && busy_ff)
   `SM4_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid_ff && rsp_stall,
                    rsp_valid_ff && $stable(out_high_ff))

endmodule

// ===== bench/ctr_keystream_scoreboard.sv =====
// Scoreboard for the SM4 counter-mode engine: a predictor of the keystream XOR
// and a queue of expected chunks. Depends on sm4ctr_pkg for opcodes, sizes and the S-box.
`timescale 1ns / 1ps
class ctr_keystream_scoreboard;

   typedef struct {
      logic [63:0] hi;
      logic [63:0] lo;
      logic [4:0]  cnt;
   } chunk_type;

   logic [31:0] round_keys [32];
   logic [63:0] ctr_high;
   logic [31:0] ctr_mid;
   logic [31:0] ctr_word;
   chunk_type   pending_chunks [$];
   int          mismatches;

   // Power-on state of the counter; round keys are written before use.
   function void clear();
      foreach (round_keys[i]) round_keys[i] = '0;
      ctr_high = '0;
      ctr_mid = '0;
      ctr_word = '0;
      pending_chunks.delete();
      mismatches = 0;
   endfunction

   // One round function: S-box substitution then linear diffusion.
   function logic [31:0] round_t(logic [31:0] v);
      logic [31:0] s;
      s = {sm4ctr_pkg::SBOX[v[31:24]], sm4ctr_pkg::SBOX[v[23:16]],
           sm4ctr_pkg::SBOX[v[15:8]], sm4ctr_pkg::SBOX[v[7:0]]};
      return s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
               ^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
   endfunction

   function logic [63:0] byte_mask(int n);
      if (n <= 0) return '0;
      if (n >= 8) return '1;
      return ~64'd0 << (64 - 8 * n);
   endfunction

   // Note an accepted request and queue the chunk it is expected to yield.
   function void note_request(logic [1:0] op, logic [4:0] idx, logic [31:0] kw,
                              logic [63:0] dh, logic [63:0] dl, logic [4:0] bc);
      logic [31:0] w [4];
      logic [31:0] nw;
      chunk_type c;
      int n;
      case (op)
         sm4ctr_pkg::OP_KEY: round_keys[idx] = kw;
         sm4ctr_pkg::OP_COUNTER: begin
            ctr_high = dh;
            ctr_mid = dl[63:32];
            ctr_word = dl[31:0];
         end
         sm4ctr_pkg::OP_CHUNK: begin
            n = bc;
            if (n != 0) begin
               if (n > 16) n = 16;
               w[0] = ctr_high[63:32]; w[1] = ctr_high[31:0];
               w[2] = ctr_mid; w[3] = ctr_word;
               for (int r = 0; r < sm4ctr_pkg::ROUND_COUNT; r++) begin
                  nw = w[0] ^ round_t(w[1] ^ w[2] ^ w[3] ^ round_keys[r]);
                  w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = nw;
               end
               c.hi = (dh ^ {w[3], w[2]}) & byte_mask(n);
               c.lo = (dl ^ {w[1], w[0]}) & byte_mask(n - 8);
               c.cnt = 5'(n);
               pending_chunks.push_back(c);
               ctr_word = ctr_word + 32'd1;
            end
         end
         default: ;
      endcase
   endfunction

   task report(string msg);
      $display("MISMATCH: %s", msg);
      mismatches++;
   endtask

   // Compare a delivered chunk with the oldest expectation.
   task check_chunk(logic [63:0] hi, logic [63:0] lo, logic [4:0] cnt);
      chunk_type c;
      if (pending_chunks.size() == 0) begin
         report("unexpected response");
         return;
      end
      c = pending_chunks.pop_front();
      if (hi !== c.hi) report($sformatf("out_high %h, wanted %h", hi, c.hi));
      if (lo !== c.lo) report($sformatf("out_low %h, wanted %h", lo, c.lo));
      if (cnt !== c.cnt) report($sformatf("out_count %0d, wanted %0d", cnt, c.cnt));
   endtask

endclass

// ===== bench/tb.sv =====
// Top-level bench for sm4_ctr_keystream_xor: drives key, counter and chunk
// requests under random idling. Depends on sm4ctr_pkg and the scoreboard class.
`timescale 1ns / 1ps
module tb;

   localparam int WATCHDOG_LIMIT = 2000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   logic [1:0]  req_opcode = '0;
   logic [4:0]  req_key_index = '0;
   logic [31:0] req_key_word = '0;
   logic [63:0] req_data_high = '0;
   logic [63:0] req_data_low = '0;
   logic [4:0]  req_byte_count = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   logic [63:0] rsp_out_high;
   logic [63:0] rsp_out_low;
   logic [4:0]  rsp_out_count;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int idle_cycles = 0;
   ctr_keystream_scoreboard chunk_board = new();

   sm4_ctr_keystream_xor dut (.*);

   always #5 clock = ~clock;

   // Receiver: randomly stall, check each accepted response.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         chunk_board.check_chunk(rsp_out_high, rsp_out_low, rsp_out_count);
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Watchdog on cycles with no handshake.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("sm4_ctr_keystream_xor test failed");
         $finish;
      end
   end

   // Present one request and hold it until accepted; valid drops only while idling.
   task automatic send_request(sm4ctr_pkg::opcode_type op, logic [4:0] idx,
                               logic [31:0] kw, logic [63:0] dh, logic [63:0] dl,
                               logic [4:0] bc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_opcode <= op;
      req_key_index <= idx;
      req_key_word <= kw;
      req_data_high <= dh;
      req_data_low <= dl;
      req_byte_count <= bc;
      do @(posedge clock); while (req_stall);
      chunk_board.note_request(op, idx, kw, dh, dl, bc);
   endtask

   // Drop valid after the last request.
   task automatic stop_requests();
      req_valid <= 0;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   task automatic load_random_keys();
      for (int i = 0; i < 32; i++)
         send_request(sm4ctr_pkg::OP_KEY, 5'(i), $urandom(), rand64(), rand64(),
                      5'($urandom()));
   endtask

   // Random phase mixing chunks, counter loads, key reloads and noise.
   task automatic random_phase(int items);
      int pick;
      for (int i = 0; i < items; i++) begin
         pick = $urandom_range(99);
         if (pick < 75)
            send_request(sm4ctr_pkg::OP_CHUNK, 5'($urandom()), $urandom(), rand64(), rand64(),
                         ($urandom_range(3) == 0) ? 5'($urandom()) : 5'd16);
         else if (pick < 83)
            send_request(sm4ctr_pkg::OP_COUNTER, 5'($urandom()), $urandom(), rand64(),
                         {$urandom(), 32'hffff_fff0 | 32'($urandom_range(15))},
                         5'($urandom()));
         else if (pick < 93)
            send_request(sm4ctr_pkg::OP_KEY, 5'($urandom()), $urandom(), rand64(), rand64(),
                         5'($urandom()));
         else
            send_request(sm4ctr_pkg::OP_RSVD, 5'($urandom()), $urandom(), rand64(), rand64(),
                         5'($urandom()));
      end
   endtask

   initial begin
      chunk_board.clear();
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: all-zero and all-one keys, counter wrap, partial, empty and oversized chunks.
      for (int i = 0; i < 32; i++) send_request(sm4ctr_pkg::OP_KEY, 5'(i), '0, '0, '0, '0);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, '0, '0, 5'd16);
      send_request(sm4ctr_pkg::OP_COUNTER, '0, '0, '1, 64'hffff_ffff_ffff_fffe, '0);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, '1, '1, 5'd16);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, '1, '1, 5'd1);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, '1, '1, 5'd8);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, '1, '1, 5'd9);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, '1, '1, 5'd0);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, '1, '1, 5'd31);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, '1, '1, 5'd17);
      send_request(sm4ctr_pkg::OP_RSVD, '1, '1, '1, '1, 5'd16);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, 64'h0123_4567_89ab_cdef,
                   64'hfedc_ba98_7654_3210, 5'd15);
      for (int i = 0; i < 32; i++) send_request(sm4ctr_pkg::OP_KEY, 5'(i), '1, '0, '0, '0);
      send_request(sm4ctr_pkg::OP_CHUNK, '0, '0, '0, '0, 5'd16);

      // Random phases with each idling pattern.
      load_random_keys();
      send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(175);
      send_idle_pct = 63; recv_stall_pct = 0;  random_phase(175);
      send_idle_pct = 0;  recv_stall_pct = 63; random_phase(175);
      send_idle_pct = 35; recv_stall_pct = 35; random_phase(175);
      stop_requests();
      recv_stall_pct = 0;

      while (chunk_board.pending_chunks.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (chunk_board.mismatches == 0 && chunk_board.pending_chunks.size() == 0)
         $display("sm4_ctr_keystream_xor test passed");
      else
         $display("sm4_ctr_keystream_xor test failed");
      $finish;
   end
endmodule
